// File: rtl/tcw_pkg.sv
package tcw_pkg;

    // fixed field widths
    localparam int CMD_W   = 3;
    localparam int CHAR_W  = 8;
    localparam int COORD_W = 8;
    localparam int CPOS_W  = 9;

    // character codes
    localparam logic [CHAR_W-1:0] BLANK       = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 3'd0,
        CMD_GOTO  = 3'd1,
        CMD_CLEAR = 3'd2,
        CMD_WRAP  = 3'd3,
        CMD_END   = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    // source of the character written by a put
    typedef enum logic [1:0] {
        SRC_ITEM,
        SRC_BLANK,
        SRC_NEWLINE,
        SRC_WORD
    } put_src_t;

    // controller to datapath
    typedef struct packed {
        logic     load_item;
        logic     put_en;
        put_src_t put_src;
        logic     cursor_goto;
        logic     cursor_home;
        logic     scroll_mark;
        logic     sweep_clr;
        logic     sweep_inc;
        logic     wr_blank;
        logic     rd_shift;
        logic     wr_shift;
        logic     rd_cell;
        logic     cap_read;
        logic     wbuf_append;
        logic     wbuf_rd;
        logic     idx_clr;
        logic     idx_inc;
        logic     wlen_clr;
        logic     out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ch_ws;
        logic             wlen_zero;
        logic             wlen_full;
        logic             col_zero;
        logic             need_nl;
        logic             overflow;
        logic             sweep_copy_end;
        logic             sweep_last;
        logic             idx_last;
        logic             out_free;
    } dp_stat_t;

endpackage

// File: rtl/tcw_if.sv
interface tcw_request_if import tcw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [CHAR_W-1:0]  char_code;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;

    modport source (output valid, command, char_code, column, row, input ready);
    modport sink   (input valid, command, char_code, column, row, output ready);
endinterface

interface tcw_response_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CPOS_W-1:0] cursor_position;
    logic [CHAR_W-1:0] read_data;
    logic              scrolled;

    modport source (output valid, cursor_position, read_data, scrolled, input ready);
    modport sink   (input valid, cursor_position, read_data, scrolled, output ready);
endinterface

// File: rtl/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/tcw_ctrl.sv
module tcw_ctrl import tcw_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_CLR,
        S_RDWAIT,
        S_FLUSH,
        S_WRD_RD,
        S_WRD_PUT,
        S_CHK,
        S_SC_RD,
        S_SC_WR,
        S_SC_BLK,
        S_POST,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_SINGLE,
        PH_SEP,
        PH_WORD
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.wr_blank = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.sweep_inc = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.cmd)
                    CMD_PUT:
                    begin
                        cmd.put_en  = 1'b1;
                        cmd.put_src = SRC_ITEM;
                        phase_next  = PH_SINGLE;
                        state_next  = S_CHK;
                    end
                    CMD_GOTO:
                    begin
                        cmd.cursor_goto = 1'b1;
                        state_next      = S_DONE;
                    end
                    CMD_CLEAR:
                    begin
                        cmd.cursor_home = 1'b1;
                        cmd.sweep_clr   = 1'b1;
                        state_next      = S_CLR;
                    end
                    CMD_WRAP:
                    begin
                        if (stat.ch_ws)
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            cmd.wbuf_append = !stat.wlen_full;
                            state_next      = S_DONE;
                        end
                    end
                    CMD_END:
                    begin
                        state_next = S_FLUSH;
                    end
                    CMD_READ:
                    begin
                        cmd.rd_cell = 1'b1;
                        state_next  = S_RDWAIT;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_CLR:
            begin
                cmd.wr_blank = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.sweep_inc = 1'b1;
                end
            end
            S_RDWAIT:
            begin
                cmd.cap_read = 1'b1;
                state_next   = S_DONE;
            end
            // separator before a buffered word
            S_FLUSH:
            begin
                if (stat.wlen_zero)
                begin
                    state_next = S_DONE;
                end
                else if (stat.need_nl)
                begin
                    cmd.put_en  = 1'b1;
                    cmd.put_src = SRC_NEWLINE;
                    phase_next  = PH_SEP;
                    state_next  = S_CHK;
                end
                else if (stat.col_zero)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_WRD_RD;
                end
                else
                begin
                    cmd.put_en  = 1'b1;
                    cmd.put_src = SRC_BLANK;
                    phase_next  = PH_SEP;
                    state_next  = S_CHK;
                end
            end
            S_WRD_RD:
            begin
                cmd.wbuf_rd = 1'b1;
                state_next  = S_WRD_PUT;
            end
            S_WRD_PUT:
            begin
                cmd.put_en  = 1'b1;
                cmd.put_src = SRC_WORD;
                phase_next  = PH_WORD;
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                if (stat.overflow)
                begin
                    cmd.scroll_mark = 1'b1;
                    state_next      = S_SC_RD;
                end
                else
                begin
                    state_next = S_POST;
                end
            end
            // scroll: copy each cell up one line, then blank the bottom row
            S_SC_RD:
            begin
                cmd.rd_shift = 1'b1;
                state_next   = S_SC_WR;
            end
            S_SC_WR:
            begin
                cmd.wr_shift  = 1'b1;
                cmd.sweep_inc = 1'b1;
                state_next    = stat.sweep_copy_end ? S_SC_BLK : S_SC_RD;
            end
            S_SC_BLK:
            begin
                cmd.wr_blank = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    cmd.sweep_inc = 1'b1;
                end
            end
            S_POST:
            begin
                case (phase_reg)
                    PH_SEP:
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_WRD_RD;
                    end
                    PH_WORD:
                    begin
                        if (stat.idx_last)
                        begin
                            cmd.wlen_clr = 1'b1;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = S_WRD_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            phase_reg <= PH_SINGLE;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// File: rtl/tcw_dp.sv
module tcw_dp import tcw_pkg::*; #(
    parameter int COLUMNS  = 32,
    parameter int LINES    = 16,
    parameter int WORD_MAX = 63
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [CMD_W-1:0]   in_command,
    input  logic [CHAR_W-1:0]  in_char_code,
    input  logic [COORD_W-1:0] in_column,
    input  logic [COORD_W-1:0] in_row,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CPOS_W-1:0]  out_cursor_position,
    output logic [CHAR_W-1:0]  out_read_data,
    output logic               out_scrolled
);

    localparam int CELLS  = COLUMNS * LINES;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(LINES + 1);
    localparam int WLEN_W = $clog2(WORD_MAX + 1);
    localparam int WIDX_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;
    localparam int FIT_W  = 10;
    localparam logic [ADDR_W-1:0] COLS_A = ADDR_W'(COLUMNS);

    logic [CMD_W-1:0]  cmd_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [COL_W-1:0]  col_in_reg;
    logic [ROW_W-1:0]  row_in_reg;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [WLEN_W-1:0] wlen_reg;
    logic [WLEN_W-1:0] idx_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic              scrolled_reg;
    logic [CHAR_W-1:0] rdata_reg;
    logic              out_valid_reg;
    logic [CPOS_W-1:0] out_cpos_reg;
    logic [CHAR_W-1:0] out_rdata_reg;
    logic              out_scr_reg;

    logic [COL_W-1:0]  col_clamp;
    logic [ROW_W-1:0]  row_clamp;
    logic [CHAR_W-1:0] put_char;
    logic [CHAR_W-1:0] put_upper;
    logic              put_nl;
    logic              col_last;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] req_addr;
    logic [ADDR_W:0]   shift_src;

    logic              scr_wr_en;
    logic [ADDR_W-1:0] scr_wr_addr;
    logic [CHAR_W-1:0] scr_wr_data;
    logic              scr_rd_en;
    logic [ADDR_W-1:0] scr_rd_addr;
    logic [CHAR_W-1:0] scr_rd_data;
    logic [CHAR_W-1:0] wbuf_rd_data;

    // clamp requested coordinates
    always_comb
    begin
        col_clamp = ({1'b0, in_column} >= 9'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                         : in_column[COL_W-1:0];
        row_clamp = ({1'b0, in_row} >= 9'(LINES)) ? ROW_W'(LINES - 1)
                                                    : in_row[ROW_W-1:0];
    end

    // cell addresses
    assign cur_addr  = ADDR_W'(ADDR_W'(cur_row_reg) * COLS_A + ADDR_W'(cur_col_reg));
    assign req_addr  = ADDR_W'(ADDR_W'(row_in_reg) * COLS_A + ADDR_W'(col_in_reg));
    assign shift_src = {1'b0, sweep_reg} + (ADDR_W + 1)'(COLUMNS);

    // character for a put
    always_comb
    begin
        case (cmd.put_src)
            SRC_ITEM:    put_char = ch_reg;
            SRC_BLANK:   put_char = BLANK;
            SRC_NEWLINE: put_char = CH_CR;
            SRC_WORD:    put_char = wbuf_rd_data;
            default:     put_char = BLANK;
        endcase
        put_nl    = (put_char == CH_CR) || (put_char == CH_LF);
        put_upper = ((put_char >= LOWER_A) && (put_char <= LOWER_Z))
                    ? put_char - CASE_OFFSET : put_char;
        col_last  = (cur_col_reg == COL_W'(COLUMNS - 1));
    end

    // cursor update
    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (cmd.cursor_home)
        begin
            cur_col_next = '0;
            cur_row_next = '0;
        end
        else if (cmd.cursor_goto)
        begin
            cur_col_next = col_in_reg;
            cur_row_next = row_in_reg;
        end
        else if (cmd.scroll_mark)
        begin
            cur_col_next = '0;
            cur_row_next = ROW_W'(LINES - 1);
        end
        else if (cmd.put_en)
        begin
            if (put_nl || col_last)
            begin
                cur_col_next = '0;
                cur_row_next = cur_row_reg + ROW_W'(1);
            end
            else
            begin
                cur_col_next = cur_col_reg + COL_W'(1);
            end
        end
    end

    // screen store ports
    always_comb
    begin
        scr_wr_en   = (cmd.put_en && !put_nl) || cmd.wr_blank || cmd.wr_shift;
        scr_wr_addr = cmd.put_en ? cur_addr : sweep_reg;
        scr_wr_data = cmd.put_en ? put_upper : (cmd.wr_shift ? scr_rd_data : BLANK);
        scr_rd_en   = cmd.rd_cell || cmd.rd_shift;
        scr_rd_addr = cmd.rd_cell ? req_addr : shift_src[ADDR_W-1:0];
    end

    tcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (scr_wr_en),
        .wr_addr (scr_wr_addr),
        .wr_data (scr_wr_data),
        .rd_en   (scr_rd_en),
        .rd_addr (scr_rd_addr),
        .rd_data (scr_rd_data)
    );

    tcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (WORD_MAX)
    ) u_word (
        .clk     (clk),
        .wr_en   (cmd.wbuf_append),
        .wr_addr (wlen_reg[WIDX_W-1:0]),
        .wr_data (ch_reg),
        .rd_en   (cmd.wbuf_rd),
        .rd_addr (idx_reg[WIDX_W-1:0]),
        .rd_data (wbuf_rd_data)
    );

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            ch_reg     <= in_char_code;
            col_in_reg <= col_clamp;
            row_in_reg <= row_clamp;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= '0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            wlen_reg     <= '0;
            idx_reg      <= '0;
            sweep_reg    <= '0;
            scrolled_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                cmd_reg <= in_command;
            end
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            if (cmd.wlen_clr)
            begin
                wlen_reg <= '0;
            end
            else if (cmd.wbuf_append)
            begin
                wlen_reg <= wlen_reg + WLEN_W'(1);
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + WLEN_W'(1);
            end
            if (cmd.sweep_clr || cmd.scroll_mark)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.sweep_inc)
            begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
            if (cmd.load_item)
            begin
                scrolled_reg <= 1'b0;
            end
            else if (cmd.scroll_mark)
            begin
                scrolled_reg <= 1'b1;
            end
        end
    end

    // read data of a read cell command
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            rdata_reg <= '0;
        end
        else if (cmd.cap_read)
        begin
            rdata_reg <= scr_rd_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_cpos_reg  <= CPOS_W'(cur_addr);
            out_rdata_reg <= rdata_reg;
            out_scr_reg   <= scrolled_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_cursor_position = out_cpos_reg;
    assign out_read_data       = out_rdata_reg;
    assign out_scrolled        = out_scr_reg;

    // status
    always_comb
    begin
        stat.cmd            = cmd_reg;
        stat.ch_ws          = ch_reg inside {BLANK, CH_TAB, CH_CR, CH_LF};
        stat.wlen_zero      = (wlen_reg == '0);
        stat.wlen_full      = (wlen_reg == WLEN_W'(WORD_MAX));
        stat.col_zero       = (cur_col_reg == '0);
        stat.need_nl        = (cur_col_reg != '0) &&
                              ((FIT_W'(cur_col_reg) + FIT_W'(wlen_reg) + FIT_W'(1))
                               > FIT_W'(COLUMNS));
        stat.overflow       = (cur_row_reg == ROW_W'(LINES));
        stat.sweep_copy_end = (sweep_reg == ADDR_W'(CELLS - COLUMNS - 1));
        stat.sweep_last     = (sweep_reg == ADDR_W'(CELLS - 1));
        stat.idx_last       = ((idx_reg + WLEN_W'(1)) == wlen_reg);
        stat.out_free       = !out_valid_reg || out_ready;
    end

endmodule

// File: rtl/text_console_writer_core.sv
// channel   | role   | payload
// ----------+--------+-------------------------------------------
// request   | sink   | command, char_code, column, row
// response  | source | cursor_position, read_data, scrolled
//
// one item at a time
// a scroll walks the store through the single screen memory port pair
// clear blanks every cell; a word flush writes its characters one at a time
// after reset the store is blanked before ready rises
// a finished result waits in the output register while the next item is taken
module text_console_writer_core import tcw_pkg::*; #(
    parameter int COLUMNS  = 32,
    parameter int LINES    = 16,
    parameter int WORD_MAX = 63
) (
    input  logic           clk,
    input  logic           rst_n,
    tcw_request_if.sink    request,
    tcw_response_if.source response
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    tcw_dp #(
        .COLUMNS  (COLUMNS),
        .LINES    (LINES),
        .WORD_MAX (WORD_MAX)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (dp_cmd),
        .stat                (dp_stat),
        .in_command          (request.command),
        .in_char_code        (request.char_code),
        .in_column           (request.column),
        .in_row              (request.row),
        .out_valid           (response.valid),
        .out_ready           (response.ready),
        .out_cursor_position (response.cursor_position),
        .out_read_data       (response.read_data),
        .out_scrolled        (response.scrolled)
    );

`ifndef SYNTHESIS
    // one item in flight
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |=> !request.ready)
        else $error("item accepted while another is in flight");

    // cursor never rests past the last row
    a_no_overflow_idle: assert property (@(posedge clk) disable iff (!rst_n)
        request.ready |-> !dp_stat.overflow)
        else $error("cursor past last row while idle");

    // one writer to the screen store per cycle
    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.put_en |-> (!dp_cmd.wr_blank && !dp_cmd.wr_shift))
        else $error("conflicting screen writes");

    // a result is only loaded when the output register is free
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> (!response.valid || response.ready))
        else $error("result overwritten");
`endif

endmodule
